>>> rtl/core/prba_pkg.sv
// Package for the page run bitmap allocator: field widths, status, operation,
// register index and controller state codes. No dependencies.
`default_nettype none

package prba_pkg;

	localparam int ADDR_W     = 32;
	localparam int COUNT_W    = 13;
	localparam int POOL_W     = 13;
	localparam int STATUS_W   = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_W     = 8;
	localparam int WORD_LOG   = 3;
	localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_SPACE = 2'd1,
		STATUS_OUTSIDE  = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		CFG_BASE_ADDRESS = 1'b0,
		CFG_POOL_PAGES   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_CHK,
		ST_SCAN,
		ST_FSET,
		ST_RD,
		ST_WR,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/prba_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on prba_pkg for field widths.
`default_nettype none

interface prba_req_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [prba_pkg::ADDR_W-1:0]  address;
	logic [prba_pkg::COUNT_W-1:0] page_count;

	modport source (output valid, output operation, output address, output page_count,
		input ready);
	modport sink (input valid, input operation, input address, input page_count,
		output ready);
endinterface

interface prba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [prba_pkg::STATUS_W-1:0] status;
	logic [prba_pkg::ADDR_W-1:0]   start_address;

	modport source (output valid, output status, output start_address, input ready);
	modport sink (input valid, input status, input start_address, output ready);
endinterface

`default_nettype wire

>>> rtl/core/page_run_bitmap_allocator_unit.sv
// Top level of the page run bitmap allocator: controller and bitmap RAM.
// Depends on prba_pkg and the channel interfaces in prba_if.sv.
`default_nettype none

// Page run bitmap allocator, first fit.
// req (sink): operation 0 allocates page_count pages (0 means 1), operation 1
//   frees page_count pages starting at the page holding address.
// rsp (source): one transfer per request, status and start_address.
// cfg: cfg_write_en / cfg_index / cfg_data, index 0 base_address, 1 pool_pages;
//   write only while no request is in flight.
// The bitmap lives in a RAM of 8-bit words (one bit per page, one read port,
//   one write port, registered read). Work is one request at a time:
//   accept, check, then
//   allocate: scan one word per cycle, then set up, read, modify and write
//     back each word of the run, finish and respond;
//   free: set up, read, modify and write back each word touched, finish and
//     respond; rejects respond right after the check.
// Reset: a clearing pass writes zero to all ceil(MAX_PAGES/8) words, one per
//   cycle, with req.ready low; config writes are taken during it. base_address
//   resets to 0 and pool_pages to 4096.
// Stall: the result sits in the output register; a new request is accepted
//   meanwhile, and a finished one waits in ST_RESP until the register frees.
module page_run_bitmap_allocator_unit #(
	parameter int MAX_PAGES = 4096
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_write_en,
	input  wire prba_pkg::cfg_reg_t             cfg_index,
	input  wire [prba_pkg::CFG_DATA_W-1:0]      cfg_data,
	prba_req_if.sink                            req,
	prba_rsp_if.source                          rsp
);
	import prba_pkg::*;

	localparam int PW    = $clog2(MAX_PAGES + 1);
	localparam int DEPTH = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = (PW > POOL_W) ? PW : POOL_W;
	localparam int SW    = LW + 1;
	localparam int IW    = ADDR_W - PAGE_SHIFT;
	localparam logic [AW-1:0] LAST_WORD  = AW'(DEPTH - 1);
	localparam logic [LW-1:0] MAX_L      = LW'(MAX_PAGES);
	localparam logic [PW-1:0] MAX_P      = PW'(MAX_PAGES);
	localparam logic [PW:0]   WORD_STEP  = (PW + 1)'(WORD_W);

	// config
	logic [ADDR_W-1:0] base_q;
	logic [POOL_W-1:0] pool_q;

	// controller
	state_t             state_q, state_d;
	logic [AW-1:0]      clr_q;
	op_t                op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COUNT_W-1:0] count_q;
	logic [PW-1:0]      need_q;
	logic [PW:0]        issue_pg_q;
	logic               scan_valid_s1;
	logic [PW-1:0]      scan_pg_s1;
	logic [PW-1:0]      run_q, rstart_q;
	logic [PW-1:0]      lo_q, hi_q;
	logic [PW:0]        cur_q;
	logic               set_q;
	status_t            res_status_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [ADDR_W-1:0]  rsp_addr_q;

	// bitmap RAM
	logic [WORD_W-1:0] mem [DEPTH];
	logic              mem_re, mem_we;
	logic [AW-1:0]     mem_raddr, mem_waddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;

	// derived values
	logic [PW-1:0]      limit;
	logic [LW-1:0]      pool_ext;
	logic [ADDR_W-1:0]  base_m;
	logic [COUNT_W-1:0] need;
	logic [ADDR_W-1:0]  diff;
	logic [IW-1:0]      idx;
	logic               outside;
	logic               req_fire, rsp_free;
	logic               scan_issue, scan_last, scan_stop;
	logic               found;
	logic [PW-1:0]      fstart, run_d, rstart_d;
	logic [SW-1:0]      amount, hi_sum;
	logic [WORD_W-1:0]  mask;
	logic               rmw_done;

	assign pool_ext = LW'(pool_q);
	assign limit    = (pool_ext > MAX_L) ? MAX_P : pool_ext[PW-1:0];
	assign base_m   = base_q & PAGE_MASK;
	assign need     = (count_q == '0) ? COUNT_W'(1) : count_q;
	assign diff     = addr_q - base_m;
	assign idx      = diff[ADDR_W-1:PAGE_SHIFT];
	assign outside  = (addr_q < base_m) || (idx >= IW'(limit));
	assign req_fire = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign rmw_done = cur_q >= {1'b0, hi_q};

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.start_address = rsp_addr_q;

	// free-run scan over one word, low page first
	always_comb begin
		logic [PW-1:0] p;
		run_d    = run_q;
		rstart_d = rstart_q;
		found    = 1'b0;
		fstart   = '0;
		p        = '0;
		for (int b = 0; b < WORD_W; b++) begin
			p = {scan_pg_s1[PW-1:WORD_LOG], WORD_LOG'(b)};
			if (!found && (p < limit)) begin
				if (mem_rdata[b]) begin
					run_d = '0;
				end else begin
					if (run_d == '0) rstart_d = p;
					run_d = run_d + 1'b1;
					if (run_d == need_q) begin
						found  = 1'b1;
						fstart = rstart_d;
					end
				end
			end
		end
	end

	assign scan_last  = ({1'b0, scan_pg_s1} + WORD_STEP) >= {1'b0, limit};
	assign scan_stop  = scan_valid_s1 && (found || scan_last);
	assign scan_issue = (issue_pg_q < {1'b0, limit}) && !scan_stop;

	// bits of the current word inside [lo, hi)
	always_comb begin
		logic [PW-1:0] p;
		mask = '0;
		p    = '0;
		for (int b = 0; b < WORD_W; b++) begin
			p       = {cur_q[PW-1:WORD_LOG], WORD_LOG'(b)};
			mask[b] = (p >= lo_q) && (p < hi_q);
		end
	end

	assign amount = (op_q == OP_FREE) ? SW'(count_q) : SW'(need_q);
	assign hi_sum = SW'(lo_q) + amount;

	// next state and RAM controls
	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = cur_q[AW+WORD_LOG-1:WORD_LOG];
		mem_waddr = cur_q[AW+WORD_LOG-1:WORD_LOG];
		mem_wdata = set_q ? (mem_rdata | mask) : (mem_rdata & ~mask);
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == LAST_WORD) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_fire) state_d = ST_CHK;
			end
			ST_CHK: begin
				if (op_q == OP_ALLOC) begin
					state_d = (LW'(need) > LW'(limit)) ? ST_RESP : ST_SCAN;
				end else begin
					state_d = outside ? ST_RESP : ST_FSET;
				end
			end
			ST_SCAN: begin
				mem_re    = scan_issue;
				mem_raddr = issue_pg_q[AW+WORD_LOG-1:WORD_LOG];
				if (scan_stop) state_d = found ? ST_FSET : ST_RESP;
			end
			ST_FSET: begin
				state_d = ST_RD;
			end
			ST_RD: begin
				if (rmw_done) begin
					state_d = ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_WR;
				end
			end
			ST_WR: begin
				mem_we  = 1'b1;
				state_d = ST_RD;
			end
			ST_RESP: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// RAM: no reset, cleared by the pass after reset
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata <= mem[mem_raddr];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pool_q <= POOL_W'(4096);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_BASE_ADDRESS: base_q <= cfg_data;
				CFG_POOL_PAGES:   pool_q <= cfg_data[POOL_W-1:0];
				default: ;
			endcase
		end
	end

	// control registers with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			scan_valid_s1 <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
			scan_valid_s1 <= (state_q == ST_SCAN) && scan_issue;
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					op_q    <= op_t'(req.operation);
					addr_q  <= req.address;
					count_q <= req.page_count;
				end
			end
			ST_CHK: begin
				need_q     <= PW'(need);
				issue_pg_q <= '0;
				run_q      <= '0;
				rstart_q   <= '0;
				lo_q       <= idx[PW-1:0];
				res_addr_q <= '0;
				res_status_q <= (op_q == OP_ALLOC) ? STATUS_NO_SPACE : STATUS_OUTSIDE;
			end
			ST_SCAN: begin
				if (scan_issue) issue_pg_q <= issue_pg_q + WORD_STEP;
				scan_pg_s1 <= issue_pg_q[PW-1:0];
				if (scan_valid_s1) begin
					run_q    <= run_d;
					rstart_q <= rstart_d;
					if (found) lo_q <= fstart;
				end
			end
			ST_FSET: begin
				hi_q  <= (hi_sum > SW'(limit)) ? limit : hi_sum[PW-1:0];
				cur_q <= {1'b0, lo_q[PW-1:WORD_LOG], WORD_LOG'(0)};
				set_q <= (op_q == OP_ALLOC);
			end
			ST_RD: begin
				if (rmw_done) begin
					res_status_q <= STATUS_OK;
					res_addr_q   <= set_q ? (base_m + (ADDR_W'(lo_q) << PAGE_SHIFT)) : '0;
				end
			end
			ST_WR: begin
				cur_q <= cur_q + WORD_STEP;
			end
			ST_RESP: begin
				if (rsp_free) begin
					rsp_status_q <= res_status_q;
					rsp_addr_q   <= res_addr_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !req.ready)
		else $error("request accepted during clearing pass");

	a_wr_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> ($past(state_q) == ST_RD && $past(mem_re)))
		else $error("write-back without a preceding read");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("bitmap written during scan");

	a_run_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_valid_s1 && found)
			|-> (SW'(fstart) + SW'(need_q) <= SW'(limit)))
		else $error("found run extends past pool end");

	a_ok_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q == STATUS_OK) |-> (rsp_addr_q[PAGE_SHIFT-1:0] == '0))
		else $error("unaligned start address");
`endif
endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for page_run_bitmap_allocator_unit: first-fit page runs,
// frees, pool bounds and register changes, checked against a bit-exact page map.
// Depends on prba_pkg and the channel interfaces in rtl/core/prba_if.sv.
`timescale 1ns / 1ps

module tb;
	import prba_pkg::*;

	localparam int MAX_PAGES      = 4096;
	localparam int PAGE_IW        = $clog2(MAX_PAGES);
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int PRINT_CAP      = 100;

	typedef struct {
		status_t               status;
		logic [ADDR_W-1:0]     start_address;
	} answer_t;

	// A run handed out by the allocator, kept by page index so it survives base changes.
	typedef struct {
		int unsigned first_page;
		int unsigned pages;
	} page_run_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write_en;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	prba_req_if req_ch ();
	prba_rsp_if rsp_ch ();

	page_run_bitmap_allocator_unit #(
		.MAX_PAGES(MAX_PAGES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	always #1 clk = ~clk;

	// Shadow of the block: page map and both registers at their reset values.
	bit                    used_pages [MAX_PAGES];
	logic [ADDR_W-1:0]     base_reg = '0;
	logic [POOL_W-1:0]     pool_reg = 13'd4096;

	answer_t               awaited_rsp [$];	// answers owed by the block, oldest first
	page_run_t             live_runs [$];	// runs the stimulus may give back
	answer_t               head_rsp;
	int unsigned           error_count = 0;
	int unsigned           idle_cycles = 0;
	int unsigned           burst_left = 0;
	int unsigned           hold_left = 0;

	// Bit-exact answer to one request; updates the shadow page map.
	function automatic void serve_request(input op_t op, input logic [ADDR_W-1:0] addr,
			input logic [COUNT_W-1:0] count, output answer_t answer);
		int unsigned       limit;
		int unsigned       need;
		int unsigned       run_len;
		int unsigned       i;
		int unsigned       idx;
		logic [ADDR_W-1:0] base;
		logic              found;
		limit = (pool_reg > MAX_PAGES) ? MAX_PAGES : pool_reg;
		base = base_reg & PAGE_MASK;	// low 12 bits of the base register do not count
		answer.status = STATUS_NO_SPACE;
		answer.start_address = '0;
		if (op == OP_ALLOC) begin
			need = (count == 0) ? 1 : count;
			run_len = 0;
			found = 1'b0;
			// need > limit can never fit, so the scan is skipped
			if (need <= limit) begin
				for (i = 0; i < limit && !found; i++) begin
					if (used_pages[PAGE_IW'(i)]) begin
						run_len = 0;
					end else begin
						run_len++;
						if (run_len == need) begin
							found = 1'b1;
							for (idx = i + 1 - need; idx <= i; idx++)
								used_pages[PAGE_IW'(idx)] = 1'b1;
							answer.status = STATUS_OK;
							// wraps modulo 2^32 near the top of the address space
							answer.start_address = base + ((i + 1 - need) << PAGE_SHIFT);
						end
					end
				end
			end
		end else if (addr < base) begin
			answer.status = STATUS_OUTSIDE;
		end else begin
			idx = (addr - base) >> PAGE_SHIFT;
			if (idx >= limit) begin
				answer.status = STATUS_OUTSIDE;
			end else begin
				// pages past the pool end are left alone; zero count clears nothing
				for (i = 0; i < count && idx + i < limit; i++)
					used_pages[PAGE_IW'(idx + i)] = 1'b0;
				answer.status = STATUS_OK;
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// One request transfer. The sender runs in bursts; between bursts valid drops
	// for a random gap. Within a burst valid stays high across back-to-back items.
	task automatic send_request(input op_t op, input logic [ADDR_W-1:0] addr,
			input logic [COUNT_W-1:0] count);
		int unsigned       gap;
		answer_t           answer;
		page_run_t         run;
		logic [ADDR_W-1:0] offset;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(1, 20);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			// now and then a long burst, so stretches with no sender gaps occur
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.address    <= addr;
		req_ch.page_count <= count;
		do @(posedge clk); while (!req_ch.ready);
		serve_request(op, addr, count, answer);
		awaited_rsp.push_back(answer);
		if (op == OP_ALLOC && answer.status == STATUS_OK) begin
			offset = answer.start_address - (base_reg & PAGE_MASK);
			run.first_page = offset >> PAGE_SHIFT;
			run.pages = (count == 0) ? 1 : count;
			live_runs.push_back(run);
		end
	endtask

	// Sender holds off until every owed answer has come back; the block is idle after.
	task automatic drain_requests();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= index;
		cfg_data     <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		if (index == CFG_BASE_ADDRESS)
			base_reg = value;
		else
			pool_reg = value[POOL_W-1:0];
	endtask

	task automatic set_pool(input logic [ADDR_W-1:0] base, input int unsigned pages);
		drain_requests();
		write_register(CFG_BASE_ADDRESS, base);
		write_register(CFG_POOL_PAGES, pages);
	endtask

	// Reset config (base 0, 4096 pages): first fit, zero counts, frees in odd places.
	task automatic test_reset_defaults();
		send_request(OP_ALLOC, 32'hDEAD_BEEF, 13'd0);		// zero count takes one page
		send_request(OP_ALLOC, 32'h0000_0000, 13'd3);
		send_request(OP_FREE,  32'h0000_17FF, 13'd1);		// address inside page 1
		send_request(OP_ALLOC, 32'h0000_0000, 13'd1);		// lowest hole is page 1 again
		send_request(OP_FREE,  32'h0000_2000, 13'd0);		// zero-count free
		send_request(OP_FREE,  32'h0006_4000, 13'd2);		// pages already free
		send_request(OP_FREE,  32'hFFFF_FFFF, 13'd1);		// far past the pool
		send_request(OP_FREE,  32'h0000_0000, 13'd4096);	// whole pool back
		send_request(OP_ALLOC, 32'h0000_0000, 13'd4096);	// whole pool in one run
		send_request(OP_ALLOC, 32'h0000_0000, 13'd1);		// full
		send_request(OP_FREE,  32'h00FA_0000, 13'd200);		// page 4000, runs past the end
		send_request(OP_ALLOC, 32'h0000_0000, 13'd96);
	endtask

	// Shrinking the pool hides used pages; growing it brings them back.
	task automatic test_pool_shrink();
		set_pool(32'h4000_0000, 64);
		send_request(OP_ALLOC, 32'h0000_0000, 13'd65);		// bigger than the pool
		send_request(OP_ALLOC, 32'h0000_0000, 13'd1);
		send_request(OP_FREE,  32'h3FFF_F000, 13'd1);		// below the base
		send_request(OP_FREE,  32'h4004_0000, 13'd1);		// first page past the end
		send_request(OP_FREE,  32'h4000_A000, 13'd100);		// clipped at page 63
		send_request(OP_ALLOC, 32'h0000_0000, 13'd54);
		set_pool(32'h4000_0000, 4096);
		send_request(OP_ALLOC, 32'h0000_0000, 13'd1);		// hidden pages kept their bits
		send_request(OP_FREE,  32'h4000_0000, 13'd4096);
	endtask

	// Base at the top page: run addresses wrap through zero.
	task automatic test_address_wrap();
		set_pool(32'hFFFF_F000, 4096);
		send_request(OP_ALLOC, 32'h0000_0000, 13'd1);
		send_request(OP_ALLOC, 32'h0000_0000, 13'd1);		// lands at address 0
		send_request(OP_FREE,  32'h0000_0000, 13'd1);		// wrapped address reads as below base
		send_request(OP_FREE,  32'hFFFF_F000, 13'd4096);
	endtask

	// Empty pool and an unaligned base value.
	task automatic test_empty_pool();
		set_pool(32'h0000_0ABC, 0);
		send_request(OP_ALLOC, 32'h0000_0000, 13'd0);
		send_request(OP_FREE,  32'h0000_0000, 13'd1);
	endtask

	// Mostly allocate/free pairs with random content, plus frees aimed at nothing.
	task automatic run_random_phase(input int unsigned items);
		int unsigned       n;
		int unsigned       r;
		int unsigned       pick;
		int unsigned       limit;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] addr;
		logic [COUNT_W-1:0] count;
		page_run_t         victim;
		for (n = 0; n < items; n++) begin
			limit = (pool_reg > MAX_PAGES) ? MAX_PAGES : pool_reg;
			base = base_reg & PAGE_MASK;
			r = $urandom_range(0, 99);
			if (r < 50) begin
				// sizes skew small so scans and run writes stay short
				pick = $urandom_range(0, 99);
				if (pick < 5)
					count = 0;
				else if (pick < 75)
					count = COUNT_W'($urandom_range(1, 8));
				else if (pick < 93)
					count = COUNT_W'($urandom_range(9, 64));
				else if (pick < 99)
					count = COUNT_W'($urandom_range(65, 512));
				else
					count = COUNT_W'($urandom_range(513, 4096));
				send_request(OP_ALLOC, $urandom, count);
			end else if (r < 85 && live_runs.size() != 0) begin
				pick = $urandom_range(0, live_runs.size() - 1);
				victim = live_runs[pick];
				live_runs.delete(pick);
				addr = base + (victim.first_page << PAGE_SHIFT);
				if ($urandom_range(0, 2) == 0)
					addr = addr + $urandom_range(0, (1 << PAGE_SHIFT) - 1);
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					count = COUNT_W'(victim.pages);
				end else if (pick < 85) begin
					count = 0;
					live_runs.push_back(victim);	// nothing was released
				end else begin
					count = (victim.pages + 8 > 4096) ? COUNT_W'(4096)
						: COUNT_W'($urandom_range(1, victim.pages + 8));
				end
				send_request(OP_FREE, addr, count);
			end else begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: begin
						addr = $urandom;
						count = COUNT_W'($urandom_range(0, 4096));
					end
					1: begin
						addr = base - $urandom_range(1, 32'h0001_0000);
						count = COUNT_W'($urandom_range(0, 16));
					end
					2: begin
						addr = base + ((limit + $urandom_range(0, 16)) << PAGE_SHIFT)
							+ $urandom_range(0, (1 << PAGE_SHIFT) - 1);
						count = COUNT_W'($urandom_range(0, 16));
					end
					default: begin
						addr = base + ($urandom_range(0, limit) << PAGE_SHIFT);
						count = COUNT_W'($urandom_range(0, 16));
					end
				endcase
				send_request(OP_FREE, addr, count);
			end
		end
	endtask

	task automatic test_random_traffic();
		logic [ADDR_W-1:0] base;
		base = $urandom;
		set_pool(base & PAGE_MASK, 4096);
		run_random_phase(400);
		set_pool(32'h0000_0000, 64);		// small pool fills up: no-space answers
		run_random_phase(250);
		base = $urandom % 32'hFFFF_F001;	// unaligned, within register range
		set_pool(base, 200);
		run_random_phase(200);
		set_pool(32'hFFFF_F000, 4096);
		run_random_phase(120);
		base = $urandom % 32'hFFFF_F001;
		set_pool(base, 1);
		run_random_phase(60);
		base = $urandom % 32'hFFFF_F001;
		set_pool(base, 0);
		run_random_phase(20);
		set_pool(32'h0000_0000, $urandom_range(65, 4095));
		run_random_phase(50);
	endtask

	// Receiver: ready held high or low for random stretches, sometimes long ones.
	always @(negedge clk) begin
		if (hold_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left = $urandom_range(1, 25);
			end else begin
				rsp_ch.ready <= 1'b1;
				hold_left = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 200 : 10);
			end
		end else begin
			hold_left--;
		end
	end

	// Response checker: every transfer against the oldest owed answer.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected response status %0d start %08h",
					rsp_ch.status, rsp_ch.start_address));
			end else begin
				head_rsp = awaited_rsp.pop_front();
				if (rsp_ch.status !== head_rsp.status)
					report_mismatch($sformatf("status %0d, want %0d",
						rsp_ch.status, head_rsp.status));
				if (rsp_ch.start_address !== head_rsp.start_address)
					report_mismatch($sformatf("start_address %08h, want %08h",
						rsp_ch.start_address, head_rsp.start_address));
			end
		end
	end

	// Watchdog: too long with no transfer on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_write_en      = 1'b0;
		cfg_index         = CFG_BASE_ADDRESS;
		cfg_data          = '0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_ALLOC;
		req_ch.address    = '0;
		req_ch.page_count = '0;
		rsp_ch.ready      = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// the block clears its map after reset with req.ready low; send just waits
		test_reset_defaults();
		test_pool_shrink();
		test_address_wrap();
		test_empty_pool();
		test_random_traffic();
		drain_requests();
		repeat (50) @(posedge clk);	// catch any stray late response
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/prba_pkg.sv
rtl/core/prba_if.sv
rtl/core/page_run_bitmap_allocator_unit.sv
tb/tb.sv
